// File: hw/rtl/nfa_pkg.sv
// nand flash array model: shared sizes, command and status codes, store entry types
// no dependencies
`timescale 1ns / 1ps

package nfa_pkg;

  localparam int BLOCKS        = 256;
  localparam int PAGES_PER_BLK = 64;
  localparam int DATA_WIDTH    = 32;

  localparam int TOTAL_PAGES = BLOCKS * PAGES_PER_BLK;
  localparam int BLK_AW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int PG_AW   = (PAGES_PER_BLK > 1) ? $clog2(PAGES_PER_BLK) : 1;
  localparam int PAGE_AW = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
  localparam int COUNT_W = 16;
  localparam int SECTOR_W = 16;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_PROG  = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_MARK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BAD   = 2'd2,
    ST_USED  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // per block: bad mark, erase count, one programmed flag per page
  typedef struct packed {
    logic                     bad;
    logic [COUNT_W-1:0]       count;
    logic [PAGES_PER_BLK-1:0] prog;
  } blk_entry_t;

  // per page: sector tag and payload, meaningful only while programmed
  typedef struct packed {
    logic [SECTOR_W-1:0]   sector;
    logic [DATA_WIDTH-1:0] payload;
  } page_entry_t;

endpackage

// File: hw/rtl/nfa_ram.sv
// generic single-clock ram: one write port, one read port with registered read data
// no dependencies
`timescale 1ns / 1ps

module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/nand_flash_array_model.sv
// nand flash array model top level: command decode, block and page stores, result register
// depends on nfa_pkg and nfa_ram
`timescale 1ns / 1ps

// usage
// - input channel (in_valid_i / in_stall_o) carries one command beat: kind, block,
//   page, write data and sector tag; kinds are read, program, erase block, mark bad
// - output channel (out_valid_o / out_stall_i) returns exactly one result beat per
//   command: status, sector and data of a read, and the block's erase count
// - sequencing: the block and page entries are read at the accept edge, and the result
//   is registered from the execute step once the result register is free; a new
//   command is taken only after the previous one leaves execute, since each command
//   reads and writes back the block store (erase and mark bad included, since the
//   per-page programmed flags live as a mask in the block entry)
// - a result waiting on out_stall_i does not block the next command from being
//   accepted; that command holds in its execute step until the result is taken
// - reset: every block entry reads as good, count zero, no page programmed, through
//   one valid flop per block; the page store needs no clearing since a page is only
//   read back while its programmed flag is set; no clearing pass is needed and the
//   block accepts commands in the first cycle after reset
module nand_flash_array_model
  import nfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          block_i,
  input  logic [5:0]          page_i,
  input  logic [31:0]         write_data_i,
  input  logic [15:0]         sector_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic signed [16:0]  read_sector_o,
  output logic [31:0]         read_data_o,
  output logic [15:0]         wear_count_o
);

  localparam int BLK_EW  = $bits(blk_entry_t);
  localparam int PAGE_EW = $bits(page_entry_t);

  // control
  state_e state_q, state_d;
  logic   in_accept;
  logic   out_free;
  logic   exec_fire;

  // latched command beat
  kind_e               kind_q;
  logic [BLK_AW-1:0]   blk_idx_q;
  logic [PG_AW-1:0]    pg_idx_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [SECTOR_W-1:0] sector_q;
  logic                range_q;

  // decode of the incoming beat
  logic                in_range;
  logic [BLK_AW-1:0]   in_blk_idx;
  logic [PG_AW-1:0]    in_pg_idx;

  // block store and per-block valid flops
  logic [BLOCKS-1:0]   blk_vld_q;
  logic                blk_vld_rd_q;
  logic [BLK_EW-1:0]   blk_rdata;
  blk_entry_t          blk_cur;
  blk_entry_t          blk_new;
  logic                blk_we;

  // page store
  logic [PAGE_AW-1:0]  in_page_addr;
  logic [PAGE_AW-1:0]  page_addr_q;
  logic [PAGE_EW-1:0]  page_rdata;
  page_entry_t         page_cur;
  page_entry_t         page_new;
  logic                page_we;

  // result
  status_e                status_d;
  logic [16:0]            rsec_d;
  logic [31:0]            rdata_d;
  logic [COUNT_W-1:0]     count_d;
  logic                   out_valid_q;
  logic [1:0]             status_q;
  logic [16:0]            rsec_q;
  logic [31:0]            rdata_q;
  logic [COUNT_W-1:0]     count_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // range check: block beyond the array, or page beyond the block for read and program
  always_comb begin
    in_range = 1'b0;
    if (int'(block_i) >= BLOCKS) begin
      in_range = 1'b1;
    end else if ((kind_e'(kind_i) == KIND_READ || kind_e'(kind_i) == KIND_PROG) &&
                 int'(page_i) >= PAGES_PER_BLK) begin
      in_range = 1'b1;
    end
  end

  assign in_blk_idx   = BLK_AW'(block_i);
  assign in_pg_idx    = PG_AW'(page_i);
  assign in_page_addr = PAGE_AW'(int'(in_blk_idx) * PAGES_PER_BLK) + PAGE_AW'(in_pg_idx);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state: idle takes a beat and issues the reads, exec retires it once
  // the result register is free
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    exec_fire  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          exec_fire = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command beat capture, payload only
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q      <= kind_e'(kind_i);
      blk_idx_q   <= in_blk_idx;
      pg_idx_q    <= in_pg_idx;
      data_q      <= DATA_WIDTH'(write_data_i);
      sector_q    <= sector_i;
      range_q     <= in_range;
      page_addr_q <= in_page_addr;
    end
  end

  // valid flops stand in for a reset of the block store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q    <= '0;
      blk_vld_rd_q <= 1'b0;
    end else begin
      if (in_accept) begin
        blk_vld_rd_q <= blk_vld_q[in_blk_idx];
      end
      if (blk_we) begin
        blk_vld_q[blk_idx_q] <= 1'b1;
      end
    end
  end

  nfa_ram #(
    .WIDTH (BLK_EW),
    .DEPTH (BLOCKS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_idx_q),
    .wdata_i (blk_new),
    .re_i    (in_accept),
    .raddr_i (in_blk_idx),
    .rdata_o (blk_rdata)
  );

  nfa_ram #(
    .WIDTH (PAGE_EW),
    .DEPTH (TOTAL_PAGES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .waddr_i (page_addr_q),
    .wdata_i (page_new),
    .re_i    (in_accept),
    .raddr_i (in_page_addr),
    .rdata_o (page_rdata)
  );

  // a block never written reads as good, unerased, all pages free
  assign blk_cur  = blk_vld_rd_q ? blk_entry_t'(blk_rdata) : '0;
  assign page_cur = page_entry_t'(page_rdata);

  // execute: read-modify-write of the block entry, page write on a good program
  always_comb begin
    blk_new  = blk_cur;
    page_new = '{sector: sector_q, payload: data_q};
    blk_we   = 1'b0;
    page_we  = 1'b0;
    status_d = ST_OK;
    rsec_d   = '0;
    rdata_d  = '0;
    count_d  = '0;
    priority if (range_q) begin
      status_d = ST_RANGE;
    end else if (blk_cur.bad) begin
      status_d = ST_BAD;
      count_d  = blk_cur.count;
    end else begin
      unique case (kind_q)
        KIND_READ: begin
          // a free page reads as erased: sector -1, all-ones payload
          if (blk_cur.prog[pg_idx_q]) begin
            rsec_d  = {1'b0, page_cur.sector};
            rdata_d = 32'(page_cur.payload);
          end else begin
            rsec_d  = '1;
            rdata_d = 32'({DATA_WIDTH{1'b1}});
          end
        end
        KIND_PROG: begin
          if (blk_cur.prog[pg_idx_q]) begin
            status_d = ST_USED;
          end else begin
            blk_new.prog[pg_idx_q] = 1'b1;
            blk_we  = exec_fire;
            page_we = exec_fire;
          end
        end
        KIND_ERASE: begin
          // count saturates, the pages are freed regardless
          if (blk_cur.count != '1) begin
            blk_new.count = blk_cur.count + COUNT_W'(1);
          end
          blk_new.prog = '0;
          blk_we = exec_fire;
        end
        KIND_MARK: begin
          blk_new.bad = 1'b1;
          blk_we = exec_fire;
        end
        default: status_d = ST_OK;
      endcase
      count_d = blk_new.count;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q <= status_d;
      rsec_q   <= rsec_d;
      rdata_q  <= rdata_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_sector_o = signed'(rsec_q);
  assign read_data_o   = rdata_q;
  assign wear_count_o  = count_q;

  // an accepted beat always moves into execute
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_EXEC)
    else $error("accepted beat did not enter execute");

  // a new result only comes out of the execute step
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EXEC)
    else $error("result raised outside execute");

  // stores are only written for an in-range, good block
  a_write_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_we |-> (state_q == S_EXEC && !range_q && !blk_cur.bad))
    else $error("block store written for a refused command");

  // a page write always goes with the flag update in its block entry
  a_page_with_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_we |-> (blk_we && kind_q == KIND_PROG && status_d == ST_OK))
    else $error("page written without its programmed flag");

endmodule

// File: tb/tb_nand_flash_array_model.sv
// self-checking bench for the nand flash array model: command beats in, one result beat out
// keeps its own page and block image to predict each result; depends on nfa_pkg and the dut
`timescale 1ns / 1ps

module tb_nand_flash_array_model;
  import nfa_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT = 5000;   // cycles with no beat on either side
  localparam int TAIL_CYCLES = 20;     // settle time after the last result
  localparam int RAND_PER_PHASE = 400;

  // hot address window so programs, reads and erases keep hitting the same pages
  localparam int HOT_BASE = 16;
  localparam int HOT_BLOCKS = 8;
  localparam int HOT_PAGES = 8;

  // block hammered with a run of erases to build up its wear count
  localparam logic [7:0] WEAR_BLK = 8'd250;
  localparam int WEAR_ERASES = 120;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  block;
    logic [5:0]  page;
    logic [31:0] data;
    logic [15:0] sector;
  } flash_cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [16:0] sector;
    logic [31:0]        data;
    logic [COUNT_W-1:0] count;
  } flash_result_t;

  // clock, reset and dut-facing signals; the ones the bench drives are known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  flash_cmd_t cmd_beat = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [1:0] res_status;
  logic signed [16:0] res_sector;
  logic [31:0] res_data;
  logic [15:0] res_count;

  // predicted flash image
  logic                  page_used [TOTAL_PAGES];
  logic signed [16:0]    page_tag [TOTAL_PAGES];
  logic [DATA_WIDTH-1:0] page_word [TOTAL_PAGES];
  logic                  blk_bad [BLOCKS];
  logic [COUNT_W-1:0]    blk_wear [BLOCKS];

  flash_cmd_t    cmd_backlog[$];      // commands not yet offered to the dut
  flash_result_t pending_results[$];  // predicted results, oldest first
  flash_cmd_t    next_cmd;
  flash_result_t oldest;

  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int results_seen = 0;
  int kind_count [4] = '{default: 0};
  int status_count [4] = '{default: 0};

  always #HALF_PERIOD clk = ~clk;

  nand_flash_array_model dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (cmd_valid),
    .in_stall_o   (cmd_stall),
    .kind_i       (cmd_beat.kind),
    .block_i      (cmd_beat.block),
    .page_i       (cmd_beat.page),
    .write_data_i (cmd_beat.data),
    .sector_i     (cmd_beat.sector),
    .out_valid_o  (res_valid),
    .out_stall_i  (res_stall),
    .status_o     (res_status),
    .read_sector_o(res_sector),
    .read_data_o  (res_data),
    .wear_count_o (res_count)
  );

  // erased page: free, sector -1, payload all ones
  function automatic void wipe_page(input int idx);
    page_used[idx] = 1'b0;
    page_tag[idx] = '1;
    page_word[idx] = '1;
  endfunction

  // apply one command to the image and return the result the dut must give
  function automatic flash_result_t flash_execute(input flash_cmd_t c);
    flash_result_t r;
    int idx;
    int base;
    bit page_cmd;
    r = '0;
    r.status = ST_OK;
    page_cmd = (c.kind == KIND_READ) || (c.kind == KIND_PROG);
    base = int'(c.block) * PAGES_PER_BLK;
    idx = base + int'(c.page);
    if (int'(c.block) >= BLOCKS) begin
      r.status = ST_RANGE;
    end else begin
      if (page_cmd && int'(c.page) >= PAGES_PER_BLK) begin
        r.status = ST_RANGE;
      end else if (blk_bad[c.block]) begin
        r.status = ST_BAD;
      end else begin
        case (c.kind)
          KIND_READ: begin
            r.sector = page_tag[idx];
            r.data = 32'(page_word[idx]);
          end
          KIND_PROG: begin
            if (page_used[idx]) begin
              r.status = ST_USED;
            end else begin
              page_used[idx] = 1'b1;
              page_tag[idx] = {1'b0, c.sector};
              page_word[idx] = DATA_WIDTH'(c.data);
            end
          end
          KIND_ERASE: begin
            // counter sticks at the top, the block is still wiped
            if (blk_wear[c.block] != '1) blk_wear[c.block] = blk_wear[c.block] + 1'b1;
            for (int j = 0; j < PAGES_PER_BLK; j++) wipe_page(base + j);
          end
          default: begin
            blk_bad[c.block] = 1'b1;
          end
        endcase
      end
      r.count = blk_wear[c.block];
    end
    return r;
  endfunction

  task automatic push_cmd(input kind_e kind, input logic [7:0] blk, input logic [5:0] pg,
                          input logic [31:0] data, input logic [15:0] sec);
    flash_cmd_t c;
    c.kind = kind;
    c.block = blk;
    c.page = pg;
    c.data = data;
    c.sector = sec;
    cmd_backlog.push_back(c);
  endtask

  // mostly traffic on a few hot blocks, some anywhere; mark bad stays rare
  task automatic push_random(input int count);
    flash_cmd_t c;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 40) c.kind = KIND_READ;
      else if (roll < 80) c.kind = KIND_PROG;
      else if (roll < 97) c.kind = KIND_ERASE;
      else c.kind = KIND_MARK;
      if ($urandom_range(99) < 80) begin
        c.block = 8'(HOT_BASE + $urandom_range(HOT_BLOCKS - 1));
        c.page = 6'($urandom_range(HOT_PAGES - 1));
      end else begin
        c.block = 8'($urandom_range(255));
        c.page = 6'($urandom_range(63));
      end
      // bad marks land anywhere except the wear block
      if (c.kind == KIND_MARK) begin
        c.block = 8'($urandom_range(255));
        if (c.block == WEAR_BLK) c.block = WEAR_BLK + 8'd1;
      end
      c.data = $urandom();
      c.sector = 16'($urandom_range(16'hFFFF));
      cmd_backlog.push_back(c);
    end
  endtask

  // sender pause: nothing offered, nothing in flight, nothing owed
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // driver: predicts each beat as it is taken, then offers the next one
  // a stalled beat holds, and the idle draw only happens once the slot is free
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        pending_results.push_back(flash_execute(cmd_beat));
        kind_count[cmd_beat.kind]++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          cmd_beat <= next_cmd;
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: each result beat against the oldest prediction, plus random back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        status_count[res_status]++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d", res_status);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("status", 32'(oldest.status), 32'(res_status));
          check_field("read_sector", 32'(oldest.sector), 32'(res_sector));
          check_field("read_data", oldest.data, res_data);
          check_field("wear_count", 32'(oldest.count), 32'(res_count));
        end
      end
      res_stall <= ($urandom_range(99) < take_idle_pct);
    end
  end

  // count cycles where neither side moves a beat
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < TOTAL_PAGES; i++) wipe_page(i);
    for (int b = 0; b < BLOCKS; b++) begin
      blk_bad[b] = 1'b0;
      blk_wear[b] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase one: slow sender, choppy receiver
    send_idle_pct = 22;
    take_idle_pct = 63;
    // fresh page reads erased, then program / read back / refuse a second program
    push_cmd(KIND_READ, 8'd0, 6'd0, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_PROG, 8'd0, 6'd0, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_READ, 8'd0, 6'd0, 32'hFFFF_FFFF, 16'hFFFF);
    push_cmd(KIND_PROG, 8'd0, 6'd0, 32'hDEAD_BEEF, 16'h1111);
    push_cmd(KIND_READ, 8'd0, 6'd0, 32'h0000_0000, 16'h0000);
    // top corner of the array with all-ones payload and tag
    push_cmd(KIND_PROG, 8'd255, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    push_cmd(KIND_READ, 8'd255, 6'd63, 32'h0000_0000, 16'h0000);
    // erase ignores the page field and frees the page for a new program
    push_cmd(KIND_ERASE, 8'd255, 6'd17, 32'h1234_5678, 16'h4321);
    push_cmd(KIND_READ, 8'd255, 6'd63, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_PROG, 8'd255, 6'd63, 32'hA5A5_5A5A, 16'h8001);
    push_cmd(KIND_READ, 8'd255, 6'd63, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_ERASE, 8'd255, 6'd0, 32'h0000_0000, 16'h0000);
    // bad block: count kept, second mark and every command refused
    push_cmd(KIND_ERASE, 8'd5, 6'd0, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_ERASE, 8'd5, 6'd0, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_PROG, 8'd5, 6'd1, 32'h0F0F_F0F0, 16'h7FFF);
    push_cmd(KIND_MARK, 8'd5, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    push_cmd(KIND_MARK, 8'd5, 6'd0, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_READ, 8'd5, 6'd1, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_PROG, 8'd5, 6'd2, 32'h0000_0001, 16'h0001);
    push_cmd(KIND_ERASE, 8'd5, 6'd0, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_READ, 8'd0, 6'd63, 32'h8000_0000, 16'h8000);
    push_random(RAND_PER_PHASE);
    wait_drained();

    // phase two: roles swapped
    send_idle_pct = 63;
    take_idle_pct = 22;
    push_random(RAND_PER_PHASE);
    wait_drained();

    // phase three: full rate both ways, then put wear on one block
    send_idle_pct = 0;
    take_idle_pct = 0;
    push_random(RAND_PER_PHASE);
    for (int n = 0; n < WEAR_ERASES; n++) begin
      push_cmd(KIND_ERASE, WEAR_BLK, 6'd0, 32'h0000_0000, 16'h0000);
    end
    // program, wipe and reprogram after the run of erases
    push_cmd(KIND_PROG, WEAR_BLK, 6'd10, 32'hCAFE_F00D, 16'hBEEF);
    push_cmd(KIND_ERASE, WEAR_BLK, 6'd10, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_READ, WEAR_BLK, 6'd10, 32'h0000_0000, 16'h0000);
    push_cmd(KIND_PROG, WEAR_BLK, 6'd10, 32'h1357_9BDF, 16'h2468);
    push_cmd(KIND_READ, WEAR_BLK, 6'd10, 32'h0000_0000, 16'h0000);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d results: %0d read, %0d program, %0d erase, %0d mark bad beats",
             results_seen, kind_count[KIND_READ], kind_count[KIND_PROG],
             kind_count[KIND_ERASE], kind_count[KIND_MARK]);
    $display("outcomes %0d ok, %0d bad block, %0d reprogram refused; wear block count %0d",
             status_count[ST_OK], status_count[ST_BAD], status_count[ST_USED],
             blk_wear[WEAR_BLK]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/nfa_pkg.sv
hw/rtl/nfa_ram.sv
hw/rtl/nand_flash_array_model.sv
tb/tb_nand_flash_array_model.sv
